FILE: hdl/gq_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the group-ordered queue.
// Depends on nothing; every other file imports it.
package gq_pkg;

    localparam int QUEUE_DEPTH_DEF = 256;
    localparam int GROUP_COUNT_DEF = 64;

    localparam int ID_W            = 16;
    localparam int GRP_W           = 6;
    localparam int STATUS_W        = 2;
    localparam int NUM_GROUP_CODES = 1 << GRP_W;

    localparam logic KIND_ENQUEUE = 1'b0;
    localparam logic KIND_DEQUEUE = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_ENQUEUED = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_DEQUEUED = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY    = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd3;

    typedef struct packed {
        logic             kind;
        logic [ID_W-1:0]  entry_id;
        logic [GRP_W-1:0] group_num;
    } gq_in_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ID_W-1:0]     out_id;
        logic [GRP_W-1:0]    out_group;
    } gq_out_t;

    typedef struct packed {
        logic             valid;
        logic [ID_W-1:0]  id;
        logic [GRP_W-1:0] grp;
        logic [GRP_W-1:0] key;
    } gq_entry_t;

    typedef enum logic [1:0] {
        TOK_SEEK,
        TOK_PUSH,
        TOK_PULL
    } gq_tok_op_t;

    typedef struct packed {
        logic       valid;
        gq_tok_op_t op;
        logic       seen;
        gq_entry_t  ent;
    } gq_tok_t;

    typedef logic [NUM_GROUP_CODES-1:0][GRP_W-1:0] gq_key_table_t;

endpackage

FILE: hdl/gq_cell.sv
`timescale 1ns / 1ps
// One queue position: holds one entry and passes a token to its right neighbor.
// Depends on gq_pkg.
module gq_cell (
    input  logic              clk,
    input  logic              rst_n,
    input  gq_pkg::gq_tok_t   tok_in,
    input  gq_pkg::gq_entry_t ent_right,
    output gq_pkg::gq_entry_t ent,
    output gq_pkg::gq_tok_t   tok_out
);
    import gq_pkg::*;

    gq_entry_t ent_reg;
    gq_entry_t ent_next;
    gq_tok_t   tok_reg;
    gq_tok_t   tok_next;

    always_comb
    begin
        ent_next       = ent_reg;
        tok_next       = tok_in;
        tok_next.valid = 1'b0;
        if (tok_in.valid)
        begin
            case (tok_in.op)
                TOK_SEEK:
                begin
                    if (!ent_reg.valid)
                    begin
                        ent_next = tok_in.ent;
                    end
                    else if (ent_reg.key == tok_in.ent.key)
                    begin
                        tok_next      = tok_in;
                        tok_next.seen = 1'b1;
                    end
                    else if (tok_in.seen)
                    begin
                        // drop in at the end of the group, carry the old word on
                        ent_next       = tok_in.ent;
                        tok_next.valid = 1'b1;
                        tok_next.op    = TOK_PUSH;
                        tok_next.ent   = ent_reg;
                    end
                    else
                    begin
                        tok_next = tok_in;
                    end
                end
                TOK_PUSH:
                begin
                    ent_next = tok_in.ent;
                    if (ent_reg.valid)
                    begin
                        tok_next.valid = 1'b1;
                        tok_next.ent   = ent_reg;
                    end
                end
                TOK_PULL:
                begin
                    ent_next = ent_right;
                    tok_next = tok_in;
                end
                default:
                begin
                    ent_next = ent_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ent_reg.valid <= 1'b0;
            tok_reg.valid <= 1'b0;
        end
        else
        begin
            ent_reg <= ent_next;
            tok_reg <= tok_next;
        end
    end

    assign ent     = ent_reg;
    assign tok_out = tok_reg;

endmodule

FILE: hdl/gq_obuf.sv
`timescale 1ns / 1ps
// Two-word result buffer between the issue stage and the result channel.
// Depends on gq_pkg.
module gq_obuf (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  gq_pkg::gq_out_t push_word,
    output logic            full,
    output logic            pop_valid,
    input  logic            pop_ready,
    output gq_pkg::gq_out_t pop_word
);
    import gq_pkg::*;

    gq_out_t    mem_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       pop;

    assign pop       = pop_valid && pop_ready;
    assign pop_valid = (count_reg != 2'd0);
    assign full      = (count_reg == 2'd2);
    assign pop_word  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

FILE: hdl/group_ordered_queue_top.sv
`timescale 1ns / 1ps
// Group-ordered queue (team queue): issue stage, row of queue cells, result buffer.
// Depends on gq_pkg, gq_cell, gq_obuf.
//
//   channel | handshake             | word
//   --------+-----------------------+-----------------------------------
//   request | req_valid / req_ready | kind, entry_id, group_num
//   result  | rsp_valid / rsp_ready | status, out_id, out_group
//
// A request word is taken only while none is pending; its status and a pending flag
// are registered, the flag pushes its result word into the result buffer, and its
// insert or remove ripples one cell per cycle, at least two cells after the last.
// Reset empties every cell at once; no clearing pass.
// A full result buffer holds req_ready low; it takes two words before it stalls.
module group_ordered_queue_top #(
    parameter int QUEUE_DEPTH = gq_pkg::QUEUE_DEPTH_DEF,
    parameter int GROUP_COUNT = gq_pkg::GROUP_COUNT_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_ready,
    input  gq_pkg::gq_in_t  req_word,
    output logic            rsp_valid,
    input  logic            rsp_ready,
    output gq_pkg::gq_out_t rsp_word
);
    import gq_pkg::*;

    localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [OCC_W-1:0] OCC_FULL = OCC_W'(QUEUE_DEPTH);
    localparam logic [OCC_W-1:0] OCC_ZERO = '0;

    function automatic gq_key_table_t build_key_table();
        gq_key_table_t tbl;
        for (int i = 0; i < NUM_GROUP_CODES; i++)
        begin
            tbl[i] = GRP_W'(i % GROUP_COUNT);
        end
        return tbl;
    endfunction

    localparam gq_key_table_t KEY_TABLE = build_key_table();

    logic                accept;
    logic                obuf_full;
    logic [OCC_W-1:0]    occ_reg;
    logic [OCC_W-1:0]    occ_next;
    gq_tok_t             tok_reg;
    gq_tok_t             tok_next;
    logic                pend_reg;
    logic                pend_next;
    logic [STATUS_W-1:0] status_reg;
    logic [STATUS_W-1:0] status_next;
    gq_out_t             result;

    gq_entry_t ent_arr [QUEUE_DEPTH];
    gq_tok_t   tok_arr [QUEUE_DEPTH];

    assign req_ready = !pend_reg && !obuf_full;
    assign accept    = req_valid && req_ready;

    always_comb
    begin
        tok_next    = '0;
        pend_next   = accept;
        status_next = status_reg;
        occ_next    = occ_reg;
        if (accept)
        begin
            if (req_word.kind == KIND_ENQUEUE)
            begin
                if (occ_reg == OCC_FULL)
                begin
                    status_next = STATUS_FULL;
                end
                else
                begin
                    status_next        = STATUS_ENQUEUED;
                    tok_next.valid     = 1'b1;
                    tok_next.op        = TOK_SEEK;
                    tok_next.seen      = 1'b0;
                    tok_next.ent.valid = 1'b1;
                    tok_next.ent.id    = req_word.entry_id;
                    tok_next.ent.grp   = req_word.group_num;
                    tok_next.ent.key   = KEY_TABLE[req_word.group_num];
                    occ_next           = occ_reg + OCC_W'(1);
                end
            end
            else
            begin
                if (occ_reg == OCC_ZERO)
                begin
                    status_next = STATUS_EMPTY;
                end
                else
                begin
                    status_next    = STATUS_DEQUEUED;
                    tok_next.valid = 1'b1;
                    tok_next.op    = TOK_PULL;
                    occ_next       = occ_reg - OCC_W'(1);
                end
            end
        end
    end

    always_comb
    begin
        result.status    = status_reg;
        result.out_id    = '0;
        result.out_group = '0;
        if (status_reg == STATUS_DEQUEUED)
        begin
            result.out_id    = ent_arr[0].id;
            result.out_group = ent_arr[0].grp;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg <= status_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg       <= '0;
            tok_reg.valid <= 1'b0;
            pend_reg      <= 1'b0;
        end
        else
        begin
            occ_reg  <= occ_next;
            tok_reg  <= tok_next;
            pend_reg <= pend_next;
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < QUEUE_DEPTH; gi++)
        begin : g_cell
            gq_tok_t   cell_tok_in;
            gq_entry_t cell_right;

            if (gi == 0)
            begin : g_first
                assign cell_tok_in = tok_reg;
            end
            else
            begin : g_rest
                assign cell_tok_in = tok_arr[gi-1];
            end

            if (gi == QUEUE_DEPTH - 1)
            begin : g_last
                assign cell_right = '0;
            end
            else
            begin : g_inner
                assign cell_right = ent_arr[gi+1];
            end

            gq_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .tok_in    (cell_tok_in),
                .ent_right (cell_right),
                .ent       (ent_arr[gi]),
                .tok_out   (tok_arr[gi])
            );
        end
    endgenerate

    gq_obuf u_obuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (pend_reg),
        .push_word (result),
        .full      (obuf_full),
        .pop_valid (rsp_valid),
        .pop_ready (rsp_ready),
        .pop_word  (rsp_word)
    );

endmodule

FILE: hdl/gq_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the group-ordered queue, bound to the top level.
// Depends on gq_pkg and group_ordered_queue_top.
module gq_port_checks (
    input logic            clk,
    input logic            rst_n,
    input logic            req_valid,
    input logic            req_ready,
    input logic            rsp_valid,
    input logic            rsp_ready,
    input gq_pkg::gq_out_t rsp_word
);
    import gq_pkg::*;

    a_issue_spacing: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request word taken on two adjacent cycles");

    a_rsp_from_req: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
        else $error("result word without a request two cycles earlier");

    a_zero_payload: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_word.status != STATUS_DEQUEUED) |->
        (rsp_word.out_id == '0) && (rsp_word.out_group == '0))
        else $error("nonzero id or group on a result that removed nothing");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_word))
        else $error("stalled result word changed or dropped");

endmodule

bind group_ordered_queue_top gq_port_checks u_gq_port_checks (.*);
